// ===== sv/pip_pkg.sv =====
package pip_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_X = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUERY_Y = 1'b1;

   // edge queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // per-vertex control carried with each queue entry
   typedef struct packed {
      logic has_edge;   // a previous vertex exists, so an ordinary edge is tested
      logic is_last;    // closing edge follows and the parity is delivered
   } edge_ctl_type;

   // back-end issue sequencer
   typedef enum logic {
      PH_EDGE,
      PH_CLOSE
   } phase_type;

endpackage

// ===== sv/pip_req_if.sv =====
interface pip_req_if #(
   parameter int CB = 32
);
   logic              valid;
   logic              ready;
   logic signed [CB-1:0] vertex_x;
   logic signed [CB-1:0] vertex_y;
   logic              is_last;

   modport source (output valid, output vertex_x, output vertex_y, output is_last,
                   input ready);
   modport sink   (input valid, input vertex_x, input vertex_y, input is_last,
                   output ready);
endinterface

// ===== sv/pip_rsp_if.sv =====
interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, output inside_res, input ready);
   modport sink   (input valid, input inside_res, output ready);
endinterface

// ===== sv/point_in_polygon_test.sv =====
// channel   direction  handshake            payload
// req_chan  in         valid/ready          vertex_x, vertex_y, is_last
// rsp_chan  out        valid/ready          inside_res
// csr_*     in         csr_we (no ready)    csr_index, csr_wdata
//
// one vertex transfer per cycle while the edge queue is not full; the last vertex
// of a ring with an earlier vertex takes the edge unit twice (its own edge and the
// closing edge), the edge queue absorbs it; the result is registered after the
// four-stage edge pipeline (differences, split products, product sums, compare)
// reset is synchronous and clears the query point, ring state, queue and pipeline
// a stalled result holds the edge pipeline; vertices keep flowing until the
// queue is full
module point_in_polygon_test
   import pip_pkg::*;
#(
   parameter int COORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   pip_req_if.sink                       req_chan,
   pip_rsp_if.source                     rsp_chan,
   input  logic                          csr_we,
   input  logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  logic signed [COORD_BITS-1:0]  csr_wdata
);

   localparam int CTLW = $bits(edge_ctl_type);
   localparam int QW   = 6 * COORD_BITS + CTLW;

   // query point registers
   logic signed [COORD_BITS-1:0] query_x_ff, query_x_in;
   logic signed [COORD_BITS-1:0] query_y_ff, query_y_in;

   // front to queue
   logic                         push, q_full;
   edge_ctl_type                 f_ctl;
   logic signed [COORD_BITS-1:0] f_xa, f_ya, f_xb, f_yb, f_fx, f_fy;

   // queue to back
   logic                         pop, head_valid;
   logic [QW-1:0]                head_data;
   edge_ctl_type                 b_ctl;
   logic signed [COORD_BITS-1:0] b_xa, b_ya, b_xb, b_yb, b_fx, b_fy;

   // configuration writes
   always_comb begin
      query_x_in = query_x_ff;
      query_y_in = query_y_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_QUERY_X: query_x_in = csr_wdata;
            CSR_QUERY_Y: query_y_in = csr_wdata;
            default: begin
               query_x_in = query_x_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_x_ff <= '0;
         query_y_ff <= '0;
      end else begin
         query_x_ff <= query_x_in;
         query_y_ff <= query_y_in;
      end
   end

   // front: tracks first and previous vertex, forms edge work per transfer
   pip_front #(
      .CB (COORD_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (push),
      .q_ctl    (f_ctl),
      .q_xa     (f_xa),
      .q_ya     (f_ya),
      .q_xb     (f_xb),
      .q_yb     (f_yb),
      .q_fx     (f_fx),
      .q_fy     (f_fy)
   );

   // short edge queue decoupling front and back
   pip_queue #(
      .W (QW)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  ({f_ctl, f_xa, f_ya, f_xb, f_yb, f_fx, f_fy}),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   assign {b_ctl, b_xa, b_ya, b_xb, b_yb, b_fx, b_fy} = head_data;

   // back: edge crossing pipeline, parity and result register
   pip_back #(
      .CB (COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (head_valid),
      .q_ctl    (b_ctl),
      .q_xa     (b_xa),
      .q_ya     (b_ya),
      .q_xb     (b_xb),
      .q_yb     (b_yb),
      .q_fx     (b_fx),
      .q_fy     (b_fy),
      .q_pop    (pop),
      .query_x  (query_x_ff),
      .query_y  (query_y_ff),
      .rsp_chan (rsp_chan)
   );

endmodule

// ===== sv/pip_queue.sv =====
module pip_queue
   import pip_pkg::*;
#(
   parameter int W = 194
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] push_data,
   output logic         full,
   input  logic         pop,
   output logic         head_valid,
   output logic [W-1:0] head_data
);

   logic [W-1:0]              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push, do_pop;

   assign full       = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== sv/pip_front.sv =====
module pip_front
   import pip_pkg::*;
#(
   parameter int CB = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   pip_req_if.sink               req_chan,
   input  logic                  q_full,
   output logic                  q_push,
   output edge_ctl_type          q_ctl,
   output logic signed [CB-1:0]  q_xa,
   output logic signed [CB-1:0]  q_ya,
   output logic signed [CB-1:0]  q_xb,
   output logic signed [CB-1:0]  q_yb,
   output logic signed [CB-1:0]  q_fx,
   output logic signed [CB-1:0]  q_fy
);

   logic signed [CB-1:0] first_x_ff, first_y_ff;
   logic signed [CB-1:0] prev_x_ff, prev_y_ff;
   logic                 mid_ring_ff, mid_ring_in;
   logic                 accept;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;

   // a lone first vertex that is not last produces no edge work
   assign q_push         = accept && (mid_ring_ff || req_chan.is_last);
   assign q_ctl.has_edge = mid_ring_ff;
   assign q_ctl.is_last  = req_chan.is_last;
   assign q_xa           = prev_x_ff;
   assign q_ya           = prev_y_ff;
   assign q_xb           = req_chan.vertex_x;
   assign q_yb           = req_chan.vertex_y;
   assign q_fx           = mid_ring_ff ? first_x_ff : req_chan.vertex_x;
   assign q_fy           = mid_ring_ff ? first_y_ff : req_chan.vertex_y;

   always_comb begin
      mid_ring_in = mid_ring_ff;
      if (accept) begin
         mid_ring_in = !req_chan.is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ring_ff <= 1'b0;
      end else begin
         mid_ring_ff <= mid_ring_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         prev_x_ff <= req_chan.vertex_x;
         prev_y_ff <= req_chan.vertex_y;
         if (!mid_ring_ff) begin
            first_x_ff <= req_chan.vertex_x;
            first_y_ff <= req_chan.vertex_y;
         end
      end
   end

endmodule

// ===== sv/pip_back.sv =====
module pip_back
   import pip_pkg::*;
#(
   parameter int CB = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_valid,
   input  edge_ctl_type         q_ctl,
   input  logic signed [CB-1:0] q_xa,
   input  logic signed [CB-1:0] q_ya,
   input  logic signed [CB-1:0] q_xb,
   input  logic signed [CB-1:0] q_yb,
   input  logic signed [CB-1:0] q_fx,
   input  logic signed [CB-1:0] q_fy,
   output logic                 q_pop,
   input  logic signed [CB-1:0] query_x,
   input  logic signed [CB-1:0] query_y,
   pip_rsp_if.source            rsp_chan
);

   localparam int DW  = CB + 1;       // difference width
   localparam int H   = DW / 2;       // low split width
   localparam int HW  = DW - H;       // high split width
   localparam int PW  = 2 * DW;       // full product width
   localparam int LLW = 2 * H;
   localparam int MXW = H + 1 + HW;
   localparam int HHW = 2 * HW;

   phase_type phase_ff, phase_in;
   logic      adv, issue, close_sel;

   logic signed [CB-1:0] e_xa, e_ya, e_xb, e_yb;
   logic signed [DW-1:0] e_u, e_d, e_w, e_v;
   logic                 e_span;

   // stage 1: differences
   logic                 s1_valid_ff, s1_emit_ff, s1_span_ff, s1_dpos_ff;
   logic signed [DW-1:0] s1_u_ff, s1_d_ff, s1_w_ff, s1_v_ff;

   // stage 2: partial products
   logic                  s2_valid_ff, s2_emit_ff, s2_span_ff, s2_dpos_ff;
   logic [LLW-1:0]        s2_l_ll_ff, s2_r_ll_ff;
   logic signed [MXW-1:0] s2_l_lh_ff, s2_l_hl_ff, s2_r_lh_ff, s2_r_hl_ff;
   logic signed [HHW-1:0] s2_l_hh_ff, s2_r_hh_ff;

   // stage 3: full products
   logic                 s3_valid_ff, s3_emit_ff, s3_span_ff, s3_dpos_ff;
   logic signed [PW-1:0] s3_lhs_ff, s3_rhs_ff;

   logic signed [PW-1:0] lhs_sum, rhs_sum;
   logic                 hit, parity_ff, parity_in, parity_next;
   logic                 rsp_valid_ff, rsp_valid_in, rsp_inside_ff;

   assign adv = !rsp_valid_ff || rsp_chan.ready;

   // ---- issue sequencer
   always_comb begin
      phase_in = phase_ff;
      if (issue) begin
         unique case (phase_ff)
            PH_EDGE: begin
               if (q_ctl.has_edge && q_ctl.is_last) begin
                  phase_in = PH_CLOSE;
               end
            end
            PH_CLOSE: begin
               phase_in = PH_EDGE;
            end
            default: begin
               phase_in = PH_EDGE;
            end
         endcase
      end
   end

   always_comb begin
      issue     = q_valid && adv;
      close_sel = (phase_ff == PH_CLOSE) || !q_ctl.has_edge;
      q_pop     = issue && (close_sel || !q_ctl.is_last);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_EDGE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // ---- edge selection and differences
   assign e_xa = close_sel ? q_xb : q_xa;
   assign e_ya = close_sel ? q_yb : q_ya;
   assign e_xb = close_sel ? q_fx : q_xb;
   assign e_yb = close_sel ? q_fy : q_yb;

   assign e_span = ((e_ya <= query_y) && (query_y < e_yb)) ||
                   ((e_yb <= query_y) && (query_y < e_ya));
   assign e_d = DW'(e_yb) - DW'(e_ya);
   assign e_u = DW'(query_x) - DW'(e_xa);
   assign e_w = DW'(e_xb) - DW'(e_xa);
   assign e_v = DW'(query_y) - DW'(e_ya);

   // ---- full product sums
   always_comb begin
      logic signed [PW-1:0] l_hh, l_mid, l_ll, r_hh, r_mid, r_ll;
      l_hh  = PW'(s2_l_hh_ff);
      l_mid = PW'(s2_l_lh_ff) + PW'(s2_l_hl_ff);
      l_ll  = PW'(s2_l_ll_ff);
      r_hh  = PW'(s2_r_hh_ff);
      r_mid = PW'(s2_r_lh_ff) + PW'(s2_r_hl_ff);
      r_ll  = PW'(s2_r_ll_ff);
      lhs_sum = (l_hh << LLW) + (l_mid << H) + l_ll;
      rhs_sum = (r_hh << LLW) + (r_mid << H) + r_ll;
   end

   // ---- crossing decision and parity
   always_comb begin
      hit          = s3_span_ff && (s3_dpos_ff ? (s3_lhs_ff < s3_rhs_ff)
                                               : (s3_rhs_ff < s3_lhs_ff));
      parity_next  = parity_ff ^ hit;
      parity_in    = parity_ff;
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = s3_valid_ff && s3_emit_ff;
         if (s3_valid_ff) begin
            parity_in = s3_emit_ff ? 1'b0 : parity_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         parity_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (adv) begin
            s1_valid_ff <= issue;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         parity_ff    <= parity_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_emit_ff <= close_sel;
         s1_span_ff <= e_span;
         s1_dpos_ff <= (e_d > 0);
         s1_u_ff    <= e_u;
         s1_d_ff    <= e_d;
         s1_w_ff    <= e_w;
         s1_v_ff    <= e_v;

         s2_emit_ff <= s1_emit_ff;
         s2_span_ff <= s1_span_ff;
         s2_dpos_ff <= s1_dpos_ff;
         s2_l_ll_ff <= LLW'(s1_u_ff[H-1:0]) * LLW'(s1_d_ff[H-1:0]);
         s2_l_lh_ff <= $signed({1'b0, s1_u_ff[H-1:0]}) * $signed(s1_d_ff[DW-1:H]);
         s2_l_hl_ff <= $signed(s1_u_ff[DW-1:H]) * $signed({1'b0, s1_d_ff[H-1:0]});
         s2_l_hh_ff <= $signed(s1_u_ff[DW-1:H]) * $signed(s1_d_ff[DW-1:H]);
         s2_r_ll_ff <= LLW'(s1_w_ff[H-1:0]) * LLW'(s1_v_ff[H-1:0]);
         s2_r_lh_ff <= $signed({1'b0, s1_w_ff[H-1:0]}) * $signed(s1_v_ff[DW-1:H]);
         s2_r_hl_ff <= $signed(s1_w_ff[DW-1:H]) * $signed({1'b0, s1_v_ff[H-1:0]});
         s2_r_hh_ff <= $signed(s1_w_ff[DW-1:H]) * $signed(s1_v_ff[DW-1:H]);

         s3_emit_ff <= s2_emit_ff;
         s3_span_ff <= s2_span_ff;
         s3_dpos_ff <= s2_dpos_ff;
         s3_lhs_ff  <= lhs_sum;
         s3_rhs_ff  <= rhs_sum;

         if (s3_valid_ff && s3_emit_ff) begin
            rsp_inside_ff <= parity_next;
         end
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.inside_res = rsp_inside_ff;

endmodule
